>>> design/kmsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kmsf_pkg;

  localparam int FIFO_DEPTH    = 16;
  localparam int PTR_W         = $clog2(FIFO_DEPTH);
  localparam int SCREEN_HEIGHT = 768;

  localparam int MODE_W   = 3;
  localparam int COORD_W  = 10;
  localparam int BUTTON_W = 3;
  localparam int KEY_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 29;

  localparam logic [BYTE_W-1:0] CODE_EXT = 8'hE0;
  localparam logic [BYTE_W-1:0] CODE_BRK = 8'hF0;

  localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(SCREEN_HEIGHT - 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_MOVE        = 3'd0,
    MODE_BTN_PRESS   = 3'd1,
    MODE_BTN_RELEASE = 3'd2,
    MODE_KEY_PRESS   = 3'd3,
    MODE_KEY_RELEASE = 3'd4,
    MODE_STATUS_READ = 3'd5,
    MODE_DATA_READ   = 3'd6
  } mode_t;

  typedef struct packed {
    logic              hit;
    logic              ext;
    logic [BYTE_W-1:0] code;
  } keymap_t;

  // host keycode to scan code set 2
  function automatic keymap_t keymap_lookup(input logic [KEY_W-1:0] key);
    keymap_t r;
    r = '{hit: 1'b1, ext: 1'b0, code: 8'h00};
    unique case (key)
      8'h09: r.code = 8'h76;  8'h43: r.code = 8'h05;  8'h44: r.code = 8'h06;
      8'h45: r.code = 8'h04;  8'h46: r.code = 8'h0C;  8'h47: r.code = 8'h03;
      8'h48: r.code = 8'h0B;  8'h49: r.code = 8'h83;  8'h4A: r.code = 8'h0A;
      8'h4B: r.code = 8'h01;  8'h4C: r.code = 8'h09;  8'h5F: r.code = 8'h78;
      8'h60: r.code = 8'h07;
      8'h31: r.code = 8'h0E;  8'h0A: r.code = 8'h16;  8'h0B: r.code = 8'h1E;
      8'h0C: r.code = 8'h26;  8'h0D: r.code = 8'h25;  8'h0E: r.code = 8'h2E;
      8'h0F: r.code = 8'h36;  8'h10: r.code = 8'h3D;  8'h11: r.code = 8'h3E;
      8'h12: r.code = 8'h46;  8'h13: r.code = 8'h45;  8'h14: r.code = 8'h4E;
      8'h15: r.code = 8'h55;  8'h16: r.code = 8'h66;
      8'h17: r.code = 8'h0D;  8'h18: r.code = 8'h15;  8'h19: r.code = 8'h1D;
      8'h1A: r.code = 8'h24;  8'h1B: r.code = 8'h2D;  8'h1C: r.code = 8'h2C;
      8'h1D: r.code = 8'h35;  8'h1E: r.code = 8'h3C;  8'h1F: r.code = 8'h43;
      8'h20: r.code = 8'h44;  8'h21: r.code = 8'h4D;  8'h22: r.code = 8'h54;
      8'h23: r.code = 8'h5B;  8'h24: r.code = 8'h5A;  8'h4E: r.code = 8'h7E;
      8'h42: r.code = 8'h58;  8'h26: r.code = 8'h1C;  8'h27: r.code = 8'h1B;
      8'h28: r.code = 8'h23;  8'h29: r.code = 8'h2B;  8'h2A: r.code = 8'h34;
      8'h2B: r.code = 8'h33;  8'h2C: r.code = 8'h3B;  8'h2D: r.code = 8'h42;
      8'h2E: r.code = 8'h4B;  8'h2F: r.code = 8'h4C;  8'h30: r.code = 8'h52;
      8'h33: r.code = 8'h5D;
      8'h32: r.code = 8'h12;  8'h5E: r.code = 8'h61;  8'h34: r.code = 8'h1A;
      8'h35: r.code = 8'h22;  8'h36: r.code = 8'h21;  8'h37: r.code = 8'h2A;
      8'h38: r.code = 8'h32;  8'h39: r.code = 8'h31;  8'h3A: r.code = 8'h3A;
      8'h3B: r.code = 8'h41;  8'h3C: r.code = 8'h49;  8'h3D: r.code = 8'h4A;
      8'h3E: r.code = 8'h59;
      8'h25: r.code = 8'h14;
      8'h73: begin r.code = 8'h69; r.ext = 1'b1; end
      8'h40: r.code = 8'h11;  8'h41: r.code = 8'h29;
      8'h71: begin r.code = 8'h6B; r.ext = 1'b1; end
      8'h74: begin r.code = 8'h72; r.ext = 1'b1; end
      8'h75: begin r.code = 8'h7A; r.ext = 1'b1; end
      8'h6D: begin r.code = 8'h14; r.ext = 1'b1; end
      8'h6F: begin r.code = 8'h75; r.ext = 1'b1; end
      8'h72: begin r.code = 8'h74; r.ext = 1'b1; end
      8'h6A: begin r.code = 8'h4A; r.ext = 1'b1; end
      8'h61: begin r.code = 8'h6C; r.ext = 1'b1; end
      8'h63: begin r.code = 8'h7D; r.ext = 1'b1; end
      8'h6B: begin r.code = 8'h71; r.ext = 1'b1; end
      8'h67: begin r.code = 8'h69; r.ext = 1'b1; end
      8'h69: begin r.code = 8'h7A; r.ext = 1'b1; end
      8'h62: begin r.code = 8'h75; r.ext = 1'b1; end
      8'h64: begin r.code = 8'h6B; r.ext = 1'b1; end
      8'h68: begin r.code = 8'h5A; r.ext = 1'b1; end
      8'h66: begin r.code = 8'h74; r.ext = 1'b1; end
      8'h4D: r.code = 8'h77;
      8'h70: begin r.code = 8'h7D; r.ext = 1'b1; end
      8'h3F: r.code = 8'h7C;  8'h52: r.code = 8'h7B;  8'h4F: r.code = 8'h6C;
      8'h50: r.code = 8'h75;  8'h51: r.code = 8'h7D;  8'h56: r.code = 8'h79;
      8'h53: r.code = 8'h6B;  8'h54: r.code = 8'h73;  8'h55: r.code = 8'h74;
      8'h57: r.code = 8'h69;  8'h58: r.code = 8'h72;  8'h59: r.code = 8'h7A;
      8'h6C: begin r.code = 8'h11; r.ext = 1'b1; end
      8'h5A: r.code = 8'h70;  8'h5B: r.code = 8'h71;
      8'h6E: begin r.code = 8'h6C; r.ext = 1'b1; end
      8'h76: begin r.code = 8'h70; r.ext = 1'b1; end
      8'h77: begin r.code = 8'h71; r.ext = 1'b1; end
      8'h85: begin r.code = 8'h1F; r.ext = 1'b1; end
      8'h86: begin r.code = 8'h27; r.ext = 1'b1; end
      8'h87: begin r.code = 8'h2F; r.ext = 1'b1; end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/kmsf_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface kmsf_req_if import kmsf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [COORD_W-1:0]  pointer_x;
  logic [COORD_W-1:0]  pointer_y;
  logic [BUTTON_W-1:0] button_number;
  logic [KEY_W-1:0]    key_code;

  modport source (output valid, mode, pointer_x, pointer_y, button_number, key_code,
                  input ready);
  modport sink   (input valid, mode, pointer_x, pointer_y, button_number, key_code,
                  output ready);
endinterface

interface kmsf_rsp_if import kmsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

`default_nettype wire

>>> design/keyboard_mouse_scan_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// a read result goes from the stage register into the result register
// one request per cycle unless a read stalls; key events push up to three bytes at once
// the stage register holds a request until the result register can take it
// reset clears fifo pointers, pointer position and buttons; fifo bytes are not cleared
module keyboard_mouse_scan_fifo import kmsf_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  kmsf_req_if.sink     req,
  kmsf_rsp_if.source   rsp
);

  // stage register
  logic                s_valid;
  logic [MODE_W-1:0]   s_mode;
  logic [COORD_W-1:0]  s_x;
  logic [COORD_W-1:0]  s_y;
  logic [BUTTON_W-1:0] s_btn;
  logic [KEY_W-1:0]    s_key;

  // block state
  logic [BYTE_W-1:0]   scan_fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]    rd_ptr, rd_ptr_next;
  logic [COORD_W-1:0]  mouse_x, mouse_x_next;
  logic [COORD_W-1:0]  mouse_y, mouse_y_next;
  logic [BUTTON_W-1:0] button_bits, button_bits_next;

  // result register
  logic                o_valid;
  logic [WORD_W-1:0]   o_data, o_data_next;

  logic                has_result;
  logic                advance;
  logic                key_ready;
  keymap_t             km;
  logic                key_evt;
  logic                release_evt;
  logic [BYTE_W-1:0]   bytes [3];
  logic [1:0]          n_bytes;
  logic [1:0]          n_push;
  logic [PTR_W-1:0]    used;
  logic [PTR_W-1:0]    free;
  logic [BUTTON_W-1:0] btn_mask;
  logic [COORD_W-1:0]  y_clamped;

  assign has_result = (s_mode == MODE_STATUS_READ) || (s_mode == MODE_DATA_READ);
  assign advance    = s_valid && (!has_result || !o_valid || rsp.ready);
  assign req.ready  = !s_valid || advance;
  assign rsp.valid  = o_valid;
  assign rsp.read_data = o_data;

  assign key_ready = (wr_ptr != rd_ptr);
  assign used      = wr_ptr - rd_ptr;
  assign free      = PTR_W'(FIFO_DEPTH - 1) - used;

  always_comb begin
    km          = keymap_lookup(s_key);
    key_evt     = ((s_mode == MODE_KEY_PRESS) || (s_mode == MODE_KEY_RELEASE)) && km.hit;
    release_evt = (s_mode == MODE_KEY_RELEASE);
    bytes[0]    = km.code;
    bytes[1]    = km.code;
    bytes[2]    = km.code;
    n_bytes     = 2'd1;
    unique case ({km.ext, release_evt})
      2'b00: n_bytes = 2'd1;
      2'b01: begin bytes[0] = CODE_BRK; n_bytes = 2'd2; end
      2'b10: begin bytes[0] = CODE_EXT; n_bytes = 2'd2; end
      2'b11: begin bytes[0] = CODE_EXT; bytes[1] = CODE_BRK; n_bytes = 2'd3; end
      default: n_bytes = 2'd1;
    endcase
    // bytes past a full fifo are dropped, so only the leading ones land
    if (!key_evt) begin
      n_push = 2'd0;
    end else if ({{(PTR_W > 2 ? PTR_W - 2 : 0){1'b0}}, n_bytes} > free) begin
      n_push = free[1:0];
    end else begin
      n_push = n_bytes;
    end
  end

  always_comb begin
    unique case (s_btn)
      3'd1:    btn_mask = 3'b100;
      3'd2:    btn_mask = 3'b010;
      3'd3:    btn_mask = 3'b001;
      default: btn_mask = 3'b000;
    endcase
    y_clamped = (s_y > Y_MAX) ? Y_MAX : s_y;
  end

  always_comb begin
    wr_ptr_next      = wr_ptr + PTR_W'(n_push);
    rd_ptr_next      = rd_ptr;
    mouse_x_next     = mouse_x;
    mouse_y_next     = mouse_y;
    button_bits_next = button_bits;
    o_data_next      = '0;
    if (s_valid) begin
      unique case (s_mode)
        MODE_MOVE: begin
          mouse_x_next = s_x;
          mouse_y_next = Y_MAX - y_clamped;
        end
        MODE_BTN_PRESS:   button_bits_next = button_bits | btn_mask;
        MODE_BTN_RELEASE: button_bits_next = button_bits & ~btn_mask;
        MODE_STATUS_READ: begin
          o_data_next = {key_ready, 1'b0, button_bits, 2'b00, mouse_y, 2'b00, mouse_x};
        end
        MODE_DATA_READ: begin
          if (key_ready) begin
            o_data_next = {{(WORD_W - BYTE_W){1'b0}}, scan_fifo[rd_ptr]};
            rd_ptr_next = rd_ptr + PTR_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid     <= 1'b0;
      o_valid     <= 1'b0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      mouse_x     <= '0;
      mouse_y     <= '0;
      button_bits <= '0;
    end else begin
      if (req.ready) begin
        s_valid <= req.valid;
      end
      if (advance) begin
        wr_ptr      <= wr_ptr_next;
        rd_ptr      <= rd_ptr_next;
        mouse_x     <= mouse_x_next;
        mouse_y     <= mouse_y_next;
        button_bits <= button_bits_next;
      end
      if (advance && has_result) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s_mode <= req.mode;
      s_x    <= req.pointer_x;
      s_y    <= req.pointer_y;
      s_btn  <= req.button_number;
      s_key  <= req.key_code;
    end
    if (advance && has_result) begin
      o_data <= o_data_next;
    end
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < n_push) begin
          scan_fifo[wr_ptr + PTR_W'(i)] <= bytes[i];
        end
      end
    end
  end

endmodule

`default_nettype wire
